// ----- rtl/dbn_pkg.sv -----
// Shared types, constants and register map for the detection box decoder.
`timescale 1ns / 1ps
package dbn_pkg;

   localparam int MaxCandidates = 32;
   localparam int CoordBits     = 13;
   localparam int CoordW        = 13;
   localparam int ScoreW        = 16;
   localparam int FracBits      = 17;
   localparam int ResultCap     = 32;
   localparam int EmitW         = $clog2(ResultCap);
   localparam int CsrAddrW      = 5;
   localparam int CsrDataW      = 32;

   localparam logic [2:0] RegPadLeft   = 3'd0;
   localparam logic [2:0] RegPadTop    = 3'd1;
   localparam logic [2:0] RegInvScale  = 3'd2;
   localparam logic [2:0] RegFrameW    = 3'd3;
   localparam logic [2:0] RegFrameH    = 3'd4;
   localparam logic [2:0] RegCandThr   = 3'd5;
   localparam logic [2:0] RegOverlapThr = 3'd6;

   localparam logic [15:0] InvScaleReset = 16'd4096;
   localparam logic [12:0] FrameReset    = 13'd640;
   localparam logic [15:0] CandThrReset  = 16'd16384;
   localparam logic [15:0] OverlapReset  = 16'd29491;

   typedef struct packed {
      logic [9:0]  pad_left;
      logic [9:0]  pad_top;
      logic [15:0] inverse_scale;
      logic [12:0] frame_width;
      logic [12:0] frame_height;
      logic [15:0] candidate_threshold;
      logic [15:0] overlap_threshold;
   } cfg_type;

   typedef struct packed {
      logic [ScoreW-1:0] score;
      logic [CoordW-1:0] x;
      logic [CoordW-1:0] y;
      logic [CoordW-1:0] w;
      logic [CoordW-1:0] h;
   } entry_type;

   typedef struct packed {
      logic load;
      logic dec_step;
      logic ins_start;
      logic ins_new;
      logic ins_read;
      logic ins_cmp;
      logic nms_start;
      logic nms_i_read;
      logic nms_a_load;
      logic nms_j_next;
      logic nms_j_read;
      logic nms_b;
      logic nms_u;
      logic nms_next_i;
      logic nms_set_kept;
      logic out_start;
      logic out_skip;
      logic out_read;
      logic out_load;
      logic out_empty;
      logic out_finish;
   } cmd_type;

   typedef struct packed {
      logic dec_done;
      logic keep;
      logic last;
      logic ins_top;
      logic ins_hit;
      logic nms_i_end;
      logic nms_j_end;
      logic nms_j_kept;
      logic nms_hit;
      logic out_end;
      logic out_kept;
      logic out_last;
   } status_type;

endpackage

// ----- rtl/dbn_if.sv -----
// Valid/ready channel interfaces for predictions and kept boxes.
`timescale 1ns / 1ps
interface dbn_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] center_x;
   logic signed [15:0] center_y;
   logic signed [15:0] box_span_x;
   logic signed [15:0] box_span_y;
   logic [15:0]        class_score;
   logic               last_prediction;

   modport source (output valid, center_x, center_y, box_span_x, box_span_y,
                   class_score, last_prediction, input ready);
   modport sink (input valid, center_x, center_y, box_span_x, box_span_y,
                 class_score, last_prediction, output ready);
endinterface

interface dbn_rsp_if #(parameter int COORD_BITS = dbn_pkg::CoordBits);
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] out_x;
   logic [COORD_BITS-1:0] out_y;
   logic [COORD_BITS-1:0] out_w;
   logic [COORD_BITS-1:0] out_h;
   logic [15:0]           out_score;
   logic                  box_valid;
   logic [15:0]           peak_score;
   logic                  table_overflow;
   logic                  last_result;

   modport source (output valid, out_x, out_y, out_w, out_h, out_score, box_valid,
                   peak_score, table_overflow, last_result, input ready);
   modport sink (input valid, out_x, out_y, out_w, out_h, out_score, box_valid,
                 peak_score, table_overflow, last_result, output ready);
endinterface

// ----- rtl/dbn_csr.sv -----
// APB-style configuration register file.
`timescale 1ns / 1ps
module dbn_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [dbn_pkg::CsrAddrW-1:0]   paddr,
   input  logic [dbn_pkg::CsrDataW-1:0]   pwdata,
   output logic [dbn_pkg::CsrDataW-1:0]   prdata,
   output logic                           pready,
   output dbn_pkg::cfg_type               cfg
);
   dbn_pkg::cfg_type cfg_ff;
   logic             wr_en;
   logic [2:0]       reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[4:2];
   assign cfg     = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pad_left            <= '0;
         cfg_ff.pad_top             <= '0;
         cfg_ff.inverse_scale       <= dbn_pkg::InvScaleReset;
         cfg_ff.frame_width         <= dbn_pkg::FrameReset;
         cfg_ff.frame_height        <= dbn_pkg::FrameReset;
         cfg_ff.candidate_threshold <= dbn_pkg::CandThrReset;
         cfg_ff.overlap_threshold   <= dbn_pkg::OverlapReset;
      end else if (wr_en) begin
         unique case (reg_idx)
            dbn_pkg::RegPadLeft:    cfg_ff.pad_left            <= pwdata[9:0];
            dbn_pkg::RegPadTop:     cfg_ff.pad_top             <= pwdata[9:0];
            dbn_pkg::RegInvScale:   cfg_ff.inverse_scale       <= pwdata[15:0];
            dbn_pkg::RegFrameW:     cfg_ff.frame_width         <= pwdata[12:0];
            dbn_pkg::RegFrameH:     cfg_ff.frame_height        <= pwdata[12:0];
            dbn_pkg::RegCandThr:    cfg_ff.candidate_threshold <= pwdata[15:0];
            dbn_pkg::RegOverlapThr: cfg_ff.overlap_threshold   <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         dbn_pkg::RegPadLeft:    prdata = 32'(cfg_ff.pad_left);
         dbn_pkg::RegPadTop:     prdata = 32'(cfg_ff.pad_top);
         dbn_pkg::RegInvScale:   prdata = 32'(cfg_ff.inverse_scale);
         dbn_pkg::RegFrameW:     prdata = 32'(cfg_ff.frame_width);
         dbn_pkg::RegFrameH:     prdata = 32'(cfg_ff.frame_height);
         dbn_pkg::RegCandThr:    prdata = 32'(cfg_ff.candidate_threshold);
         dbn_pkg::RegOverlapThr: prdata = 32'(cfg_ff.overlap_threshold);
         default:                prdata = '0;
      endcase
   end
endmodule

// ----- rtl/dbn_ctrl.sv -----
// Sequencer for decode, sorted insert, suppression and result output.
`timescale 1ns / 1ps
module dbn_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  dbn_pkg::status_type    st,
   output dbn_pkg::cmd_type       cmd
);
   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_DEC     = 4'd1;
   localparam logic [3:0] S_KEEP    = 4'd2;
   localparam logic [3:0] S_INS     = 4'd3;
   localparam logic [3:0] S_INS_CMP = 4'd4;
   localparam logic [3:0] S_NMS_I   = 4'd5;
   localparam logic [3:0] S_NMS_A   = 4'd6;
   localparam logic [3:0] S_NMS_J   = 4'd7;
   localparam logic [3:0] S_NMS_B   = 4'd8;
   localparam logic [3:0] S_NMS_U   = 4'd9;
   localparam logic [3:0] S_NMS_C   = 4'd10;
   localparam logic [3:0] S_OUT_I   = 4'd11;
   localparam logic [3:0] S_OUT_LD  = 4'd12;
   localparam logic [3:0] S_OUT_WT  = 4'd13;

   logic [3:0] state_ff, state_in;
   logic [3:0] after_item;

   assign after_item = st.last ? S_NMS_I : S_IDLE;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            cmd.dec_step = 1'b1;
            if (st.dec_done) state_in = S_KEEP;
         end
         S_KEEP: begin
            if (st.keep) begin
               cmd.ins_start = 1'b1;
               state_in      = S_INS;
            end else begin
               cmd.nms_start = st.last;
               state_in      = after_item;
            end
         end
         S_INS: begin
            if (st.ins_top) begin
               cmd.ins_new   = 1'b1;
               cmd.nms_start = st.last;
               state_in      = after_item;
            end else begin
               cmd.ins_read = 1'b1;
               state_in     = S_INS_CMP;
            end
         end
         S_INS_CMP: begin
            cmd.ins_cmp = 1'b1;
            if (st.ins_hit) begin
               cmd.nms_start = st.last;
               state_in      = after_item;
            end else begin
               state_in = S_INS;
            end
         end
         S_NMS_I: begin
            if (st.nms_i_end) begin
               cmd.out_start = 1'b1;
               state_in      = S_OUT_I;
            end else begin
               cmd.nms_i_read = 1'b1;
               state_in       = S_NMS_A;
            end
         end
         S_NMS_A: begin
            cmd.nms_a_load = 1'b1;
            state_in       = S_NMS_J;
         end
         S_NMS_J: begin
            priority if (st.nms_j_end) begin
               cmd.nms_set_kept = 1'b1;
               cmd.nms_next_i   = 1'b1;
               state_in         = S_NMS_I;
            end else if (!st.nms_j_kept) begin
               cmd.nms_j_next = 1'b1;
            end else begin
               cmd.nms_j_read = 1'b1;
               state_in       = S_NMS_B;
            end
         end
         S_NMS_B: begin
            cmd.nms_b = 1'b1;
            state_in  = S_NMS_U;
         end
         S_NMS_U: begin
            cmd.nms_u = 1'b1;
            state_in  = S_NMS_C;
         end
         S_NMS_C: begin
            if (st.nms_hit) begin
               cmd.nms_next_i = 1'b1;
               state_in       = S_NMS_I;
            end else begin
               cmd.nms_j_next = 1'b1;
               state_in       = S_NMS_J;
            end
         end
         S_OUT_I: begin
            priority if (st.out_end) begin
               cmd.out_empty = 1'b1;
               state_in      = S_OUT_WT;
            end else if (!st.out_kept) begin
               cmd.out_skip = 1'b1;
            end else begin
               cmd.out_read = 1'b1;
               state_in     = S_OUT_LD;
            end
         end
         S_OUT_LD: begin
            cmd.out_load = 1'b1;
            state_in     = S_OUT_WT;
         end
         S_OUT_WT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (st.out_last) begin
                  cmd.out_finish = 1'b1;
                  state_in       = S_IDLE;
               end else begin
                  state_in = S_OUT_I;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

// ----- rtl/dbn_dpath.sv -----
// Box decode, sorted candidate table, overlap test and result register.
`timescale 1ns / 1ps
module dbn_dpath #(
   parameter int MAX_CANDIDATES = dbn_pkg::MaxCandidates,
   parameter int COORD_BITS     = dbn_pkg::CoordBits
) (
   input  logic                   clock,
   input  logic                   reset,
   input  dbn_pkg::cfg_type       cfg,
   input  dbn_pkg::cmd_type       cmd,
   output dbn_pkg::status_type    st,
   input  logic signed [15:0]     center_x,
   input  logic signed [15:0]     center_y,
   input  logic signed [15:0]     box_span_x,
   input  logic signed [15:0]     box_span_y,
   input  logic [15:0]            class_score,
   input  logic                   last_prediction,
   output logic [COORD_BITS-1:0]  out_x,
   output logic [COORD_BITS-1:0]  out_y,
   output logic [COORD_BITS-1:0]  out_w,
   output logic [COORD_BITS-1:0]  out_h,
   output logic [15:0]            out_score,
   output logic                   box_valid,
   output logic [15:0]            peak_score,
   output logic                   table_overflow,
   output logic                   last_result
);
   localparam int IW = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
   localparam int CW = $clog2(MAX_CANDIDATES + 1);
   localparam int QW = 36 - dbn_pkg::FracBits;

   // input item and frame state
   logic signed [15:0] cx_ff, cy_ff, sx_ff, sy_ff;
   logic [15:0]        score_ff, peak_ff;
   logic               last_ff, ovf_ff;
   logic [CW-1:0]      count_ff;

   // decode
   logic [2:0]         step_ff;
   logic signed [35:0] prod_ff;
   logic [12:0]        coord_ff [4];
   logic [1:0]         esel, csel;
   logic signed [18:0] c19, s19, pad19, e19;
   logic signed [16:0] scale17;
   logic [12:0]        fw_top, fh_top, ctop, cval;
   logic [35:0]        p_round;
   logic [QW-1:0]      q;
   logic [13:0]        wd, hd;
   dbn_pkg::entry_type new_entry;

   // table
   dbn_pkg::entry_type tbl_mem [MAX_CANDIDATES];
   dbn_pkg::entry_type rdata_ff, wdata;
   logic [IW-1:0]      raddr;
   logic               mem_we;
   logic [CW-1:0]      pos_ff, pos_m1;
   logic               fullchk_ff, full, ins_hit;

   // suppression
   logic [CW-1:0]           ni_ff, nj_ff;
   logic [MAX_CANDIDATES-1:0] kept_ff;
   dbn_pkg::entry_type      a_ff;
   logic [13:0]             ax2, bx2, ay2, by2, ix2, iy2;
   logic [12:0]             ix1, iy1;
   logic signed [14:0]      iw, ih;
   logic [27:0]             inter_ff;
   logic [25:0]             area_a_ff, area_b_ff;
   logic                    ovl_ff;
   logic [26:0]             uni;
   logic [42:0]             uni_prod_ff;

   // output
   logic [CW-1:0]              k_ff;
   logic [dbn_pkg::EmitW-1:0]  emit_ff;
   logic                       above;
   logic [12:0]                rx_ff, ry_ff, rw_ff, rh_ff;
   logic [15:0]                rscore_ff, rpeak_ff;
   logic                       rvalid_ff, rovf_ff, rlast_ff;

   always_comb begin
      esel    = step_ff[1:0];
      c19     = esel[0] ? 19'(cy_ff) : 19'(cx_ff);
      s19     = esel[0] ? 19'(sy_ff) : 19'(sx_ff);
      pad19   = signed'({4'b0, (esel[0] ? cfg.pad_top : cfg.pad_left), 5'b0});
      e19     = (c19 <<< 1) + (esel[1] ? s19 : -s19) - pad19;
      scale17 = signed'({1'b0, cfg.inverse_scale});
   end

   always_comb begin
      csel    = 2'(step_ff[1:0] - 2'd1);
      fw_top  = (cfg.frame_width == '0) ? '0 : 13'(cfg.frame_width - 13'd1);
      fh_top  = (cfg.frame_height == '0) ? '0 : 13'(cfg.frame_height - 13'd1);
      ctop    = csel[1] ? (csel[0] ? cfg.frame_height : cfg.frame_width)
                        : (csel[0] ? fh_top : fw_top);
      p_round = csel[1] ? 36'(prod_ff) + 36'((37'd1 << dbn_pkg::FracBits) - 37'd1)
                        : 36'(prod_ff);
      q       = p_round[35:dbn_pkg::FracBits];
      if (prod_ff[35] || prod_ff == '0) begin
         cval = '0;
      end else if (q > QW'(ctop)) begin
         cval = ctop;
      end else begin
         cval = q[12:0];
      end
   end

   assign wd = {1'b0, coord_ff[2]} - {1'b0, coord_ff[0]};
   assign hd = {1'b0, coord_ff[3]} - {1'b0, coord_ff[1]};

   always_comb begin
      new_entry.score = score_ff;
      new_entry.x     = coord_ff[0];
      new_entry.y     = coord_ff[1];
      new_entry.w     = wd[12:0];
      new_entry.h     = hd[12:0];
   end

   assign full    = (count_ff == CW'(MAX_CANDIDATES));
   assign ins_hit = (rdata_ff.score >= score_ff);
   assign pos_m1  = pos_ff - CW'(1);
   assign mem_we  = cmd.ins_new || (cmd.ins_cmp && !fullchk_ff);
   assign wdata   = (cmd.ins_cmp && !ins_hit) ? rdata_ff : new_entry;

   always_comb begin
      priority if (cmd.ins_read) begin
         raddr = fullchk_ff ? IW'(MAX_CANDIDATES - 1) : pos_m1[IW-1:0];
      end else if (cmd.nms_i_read) begin
         raddr = ni_ff[IW-1:0];
      end else if (cmd.nms_j_read) begin
         raddr = nj_ff[IW-1:0];
      end else begin
         raddr = k_ff[IW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) tbl_mem[pos_ff[IW-1:0]] <= wdata;
      rdata_ff <= tbl_mem[raddr];
   end

   always_comb begin
      ax2 = {1'b0, a_ff.x} + {1'b0, a_ff.w};
      ay2 = {1'b0, a_ff.y} + {1'b0, a_ff.h};
      bx2 = {1'b0, rdata_ff.x} + {1'b0, rdata_ff.w};
      by2 = {1'b0, rdata_ff.y} + {1'b0, rdata_ff.h};
      ix1 = (a_ff.x > rdata_ff.x) ? a_ff.x : rdata_ff.x;
      iy1 = (a_ff.y > rdata_ff.y) ? a_ff.y : rdata_ff.y;
      ix2 = (ax2 < bx2) ? ax2 : bx2;
      iy2 = (ay2 < by2) ? ay2 : by2;
      iw  = signed'({1'b0, ix2} - {2'b0, ix1});
      ih  = signed'({1'b0, iy2} - {2'b0, iy1});
      uni = 27'(area_a_ff) + 27'(area_b_ff) - 27'(inter_ff);
   end

   always_comb begin
      above = 1'b0;
      for (int b = 0; b < MAX_CANDIDATES; b++) begin
         if (kept_ff[b] && (CW'(b) > k_ff)) above = 1'b1;
      end
   end

   always_comb begin
      st.dec_done   = (step_ff == 3'd4);
      st.keep       = (score_ff >= cfg.candidate_threshold) && (signed'(wd) > 14'sd1)
                      && (signed'(hd) > 14'sd1);
      st.last       = last_ff;
      st.ins_top    = (pos_ff == '0) && !fullchk_ff;
      st.ins_hit    = ins_hit;
      st.nms_i_end  = (ni_ff == count_ff);
      st.nms_j_end  = (nj_ff == ni_ff);
      st.nms_j_kept = kept_ff[nj_ff[IW-1:0]];
      st.nms_hit    = ovl_ff && ({inter_ff, 16'b0} > 44'(uni_prod_ff));
      st.out_end    = (k_ff == count_ff);
      st.out_kept   = kept_ff[k_ff[IW-1:0]];
      st.out_last   = rlast_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cx_ff    <= center_x;
         cy_ff    <= center_y;
         sx_ff    <= box_span_x;
         sy_ff    <= box_span_y;
         score_ff <= class_score;
         last_ff  <= last_prediction;
      end
      if (cmd.dec_step && !step_ff[2]) prod_ff <= e19 * scale17;
      if (cmd.dec_step && step_ff != '0) coord_ff[csel] <= cval;
      if (cmd.nms_a_load) a_ff <= rdata_ff;
      if (cmd.nms_b) begin
         inter_ff  <= iw[13:0] * ih[13:0];
         area_a_ff <= a_ff.w * a_ff.h;
         area_b_ff <= rdata_ff.w * rdata_ff.h;
         ovl_ff    <= (iw > 15'sd0) && (ih > 15'sd0);
      end
      if (cmd.nms_u) uni_prod_ff <= cfg.overlap_threshold * uni;
      if (cmd.out_load) begin
         rx_ff     <= rdata_ff.x;
         ry_ff     <= rdata_ff.y;
         rw_ff     <= rdata_ff.w;
         rh_ff     <= rdata_ff.h;
         rscore_ff <= rdata_ff.score;
         rvalid_ff <= 1'b1;
         rpeak_ff  <= peak_ff;
         rovf_ff   <= ovf_ff;
      end else if (cmd.out_empty) begin
         rx_ff     <= '0;
         ry_ff     <= '0;
         rw_ff     <= '0;
         rh_ff     <= '0;
         rscore_ff <= '0;
         rvalid_ff <= 1'b0;
         rpeak_ff  <= peak_ff;
         rovf_ff   <= ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff    <= '0;
         count_ff   <= '0;
         peak_ff    <= '0;
         ovf_ff     <= 1'b0;
         pos_ff     <= '0;
         fullchk_ff <= 1'b0;
         ni_ff      <= '0;
         nj_ff      <= '0;
         kept_ff    <= '0;
         k_ff       <= '0;
         emit_ff    <= '0;
         rlast_ff   <= 1'b0;
      end else begin
         if (cmd.load) begin
            step_ff <= '0;
            if (class_score > peak_ff) peak_ff <= class_score;
         end
         if (cmd.dec_step) step_ff <= step_ff + 3'd1;
         if (cmd.ins_start) begin
            pos_ff     <= full ? CW'(MAX_CANDIDATES - 1) : count_ff;
            fullchk_ff <= full;
            if (full) begin
               ovf_ff <= 1'b1;
            end else begin
               count_ff <= count_ff + CW'(1);
            end
         end
         if (cmd.ins_cmp && !ins_hit) begin
            if (fullchk_ff) begin
               fullchk_ff <= 1'b0;
            end else begin
               pos_ff <= pos_m1;
            end
         end
         if (cmd.nms_start) begin
            ni_ff   <= '0;
            kept_ff <= '0;
         end
         if (cmd.nms_a_load) nj_ff <= '0;
         if (cmd.nms_j_next) nj_ff <= nj_ff + CW'(1);
         if (cmd.nms_set_kept) kept_ff[ni_ff[IW-1:0]] <= 1'b1;
         if (cmd.nms_next_i) ni_ff <= ni_ff + CW'(1);
         if (cmd.out_start) begin
            k_ff    <= '0;
            emit_ff <= '0;
         end
         if (cmd.out_skip) k_ff <= k_ff + CW'(1);
         if (cmd.out_load) begin
            k_ff     <= k_ff + CW'(1);
            emit_ff  <= emit_ff + dbn_pkg::EmitW'(1);
            rlast_ff <= (emit_ff == dbn_pkg::EmitW'(dbn_pkg::ResultCap - 1)) || !above;
         end
         if (cmd.out_empty) rlast_ff <= 1'b1;
         if (cmd.out_finish) begin
            count_ff <= '0;
            peak_ff  <= '0;
            ovf_ff   <= 1'b0;
         end
      end
   end

   assign out_x          = COORD_BITS'(rx_ff);
   assign out_y          = COORD_BITS'(ry_ff);
   assign out_w          = COORD_BITS'(rw_ff);
   assign out_h          = COORD_BITS'(rh_ff);
   assign out_score      = rscore_ff;
   assign box_valid      = rvalid_ff;
   assign peak_score     = rpeak_ff;
   assign table_overflow = rovf_ff;
   assign last_result    = rlast_ff;
endmodule

// ----- rtl/detection_box_decode_and_nms.sv -----
// Top level: detection box decode with greedy overlap suppression.
//
// Predictions arrive on the req channel (valid/ready); one is taken when
// req ready is high, which happens only while the block is idle. A dropped
// prediction holds req ready low through its transfer, the decode of its left,
// top, right and bottom edges and its classification. A kept one then lands at
// the top of the table directly, or is compared down the table with each lower
// entry moved, plus one extra compare when the table is full; the candidate
// table, read and written one entry at a time, sets this cost. On a prediction
// marked last, suppression runs over the table, comparing each entry with the
// kept higher boxes until one overlaps it. Kept boxes then leave on the rsp
// channel in descending score order, one at a time, with skipped entries passed
// over; an empty frame gives one record with box_valid low. The last result
// carries last_result. A stalled rsp receiver holds the result register and the
// sequencer; no new prediction is taken until the final result of the frame
// is transferred. Configuration is written through the APB port; the user must
// write it only while idle, which the block itself does not enforce. Reset is
// synchronous; it clears the frame state and loads register defaults.
`timescale 1ns / 1ps
module detection_box_decode_and_nms #(
   parameter int MAX_CANDIDATES = dbn_pkg::MaxCandidates,
   parameter int COORD_BITS     = dbn_pkg::CoordBits
) (
   input  logic                          clock,
   input  logic                          reset,
   dbn_req_if.sink                       req,
   dbn_rsp_if.source                     rsp,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [dbn_pkg::CsrAddrW-1:0]  paddr,
   input  logic [dbn_pkg::CsrDataW-1:0]  pwdata,
   output logic [dbn_pkg::CsrDataW-1:0]  prdata,
   output logic                          pready
);
   dbn_pkg::cfg_type    cfg;
   dbn_pkg::cmd_type    cmd;
   dbn_pkg::status_type st;

   dbn_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   dbn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .st        (st),
      .cmd       (cmd)
   );

   dbn_dpath #(
      .MAX_CANDIDATES (MAX_CANDIDATES),
      .COORD_BITS     (COORD_BITS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .cmd             (cmd),
      .st              (st),
      .center_x        (req.center_x),
      .center_y        (req.center_y),
      .box_span_x      (req.box_span_x),
      .box_span_y      (req.box_span_y),
      .class_score     (req.class_score),
      .last_prediction (req.last_prediction),
      .out_x           (rsp.out_x),
      .out_y           (rsp.out_y),
      .out_w           (rsp.out_w),
      .out_h           (rsp.out_h),
      .out_score       (rsp.out_score),
      .box_valid       (rsp.box_valid),
      .peak_score      (rsp.peak_score),
      .table_overflow  (rsp.table_overflow),
      .last_result     (rsp.last_result)
   );
endmodule

// ----- test/dbn_test_if.sv -----
// Testbench types for predictions and expected results.
`timescale 1ns / 1ps
package dbn_test_pkg;
   typedef struct packed {
      logic [12:0] x;
      logic [12:0] y;
      logic [12:0] w;
      logic [12:0] h;
      logic [15:0] score;
      logic        box_valid;
      logic [15:0] peak;
      logic        overflow;
      logic        last;
   } kept_box_type;

   typedef struct packed {
      logic signed [15:0] cx;
      logic signed [15:0] cy;
      logic signed [15:0] sx;
      logic signed [15:0] sy;
      logic [15:0]        score;
      logic               last;
   } prediction_type;
endpackage

// ----- test/detection_box_decode_and_nms_test.sv -----
// Self-checking test of box decode, sorted table and greedy suppression.
`timescale 1ns / 1ps
module detection_box_decode_and_nms_test;
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [dbn_pkg::CsrAddrW-1:0] paddr = '0;
   logic [dbn_pkg::CsrDataW-1:0] pwdata = '0;
   logic [dbn_pkg::CsrDataW-1:0] prdata;
   logic pready;

   dbn_req_if req ();
   dbn_rsp_if rsp ();

   detection_box_decode_and_nms u_top (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // predictor state
   dbn_pkg::cfg_type cfg;
   logic [12:0] tab_x [dbn_pkg::MaxCandidates], tab_y [dbn_pkg::MaxCandidates];
   logic [12:0] tab_w [dbn_pkg::MaxCandidates], tab_h [dbn_pkg::MaxCandidates];
   logic [15:0] tab_score [dbn_pkg::MaxCandidates];
   int          tab_count;
   logic [15:0] frame_peak;
   logic        frame_overflow;

   dbn_test_pkg::kept_box_type expected_boxes[$];
   int errors = 0;
   int results_seen = 0;
   int frames_sent = 0;
   int items_sent = 0;
   int hold_cycles = 0;
   bit long_hold_req = 0;

   function automatic longint floor_edge(longint p, longint top);
      longint q;
      if (p <= 0) return 0;
      q = p >>> dbn_pkg::FracBits;
      return q > top ? top : q;
   endfunction

   function automatic longint ceil_edge(longint p, longint top);
      longint q;
      if (p <= 0) return 0;
      q = (p + (64'sd1 <<< dbn_pkg::FracBits) - 1) >>> dbn_pkg::FracBits;
      return q > top ? top : q;
   endfunction

   function automatic bit boxes_overlap(int a, int b);
      longint ax, ay, bx, by, ax2, ay2, bx2, by2;
      longint x1, y1, ix2, iy2, iw, ih, inter, uni;
      ax = tab_x[a]; ay = tab_y[a]; bx = tab_x[b]; by = tab_y[b];
      ax2 = ax + longint'(tab_w[a]); ay2 = ay + longint'(tab_h[a]);
      bx2 = bx + longint'(tab_w[b]); by2 = by + longint'(tab_h[b]);
      x1 = ax > bx ? ax : bx;
      y1 = ay > by ? ay : by;
      ix2 = ax2 < bx2 ? ax2 : bx2;
      iy2 = ay2 < by2 ? ay2 : by2;
      iw = ix2 - x1;
      ih = iy2 - y1;
      if (iw <= 0 || ih <= 0) return 0;
      inter = iw * ih;
      uni = longint'(tab_w[a]) * tab_h[a] + longint'(tab_w[b]) * tab_h[b] - inter;
      return inter * 65536 > longint'(cfg.overlap_threshold) * uni;
   endfunction

   task automatic insert_box(logic [12:0] bx, by, bw, bh, logic [15:0] s);
      int pos, n;
      pos = 0;
      while (pos < tab_count && tab_score[pos] >= s) pos++;
      if (tab_count >= dbn_pkg::MaxCandidates) begin
         frame_overflow = 1'b1;
         if (pos >= dbn_pkg::MaxCandidates) return;
         n = dbn_pkg::MaxCandidates - 1;
      end else begin
         n = tab_count;
         tab_count++;
      end
      for (int i = n; i > pos; i--) begin
         tab_x[i] = tab_x[i-1]; tab_y[i] = tab_y[i-1];
         tab_w[i] = tab_w[i-1]; tab_h[i] = tab_h[i-1];
         tab_score[i] = tab_score[i-1];
      end
      tab_x[pos] = bx; tab_y[pos] = by; tab_w[pos] = bw; tab_h[pos] = bh;
      tab_score[pos] = s;
   endtask

   task automatic predict_kept_boxes(dbn_test_pkg::prediction_type p);
      longint s, px, py, fw, fh, x1, y1, x2, y2;
      bit kept [dbn_pkg::MaxCandidates];
      bit hit;
      int emitted;
      dbn_test_pkg::kept_box_type r;
      if (p.score > frame_peak) frame_peak = p.score;
      if (p.score >= cfg.candidate_threshold) begin
         s = cfg.inverse_scale;
         px = 32 * longint'(cfg.pad_left);
         py = 32 * longint'(cfg.pad_top);
         fw = cfg.frame_width;
         fh = cfg.frame_height;
         x1 = floor_edge((2 * longint'(p.cx) - p.sx - px) * s, fw > 0 ? fw - 1 : 0);
         y1 = floor_edge((2 * longint'(p.cy) - p.sy - py) * s, fh > 0 ? fh - 1 : 0);
         x2 = ceil_edge((2 * longint'(p.cx) + p.sx - px) * s, fw);
         y2 = ceil_edge((2 * longint'(p.cy) + p.sy - py) * s, fh);
         if (x2 - x1 > 1 && y2 - y1 > 1)
            insert_box(13'(x1), 13'(y1), 13'(x2 - x1), 13'(y2 - y1), p.score);
      end
      if (!p.last) return;
      emitted = 0;
      for (int i = 0; i < tab_count; i++) begin
         hit = 0;
         for (int j = 0; j < i && !hit; j++)
            if (kept[j] && boxes_overlap(i, j)) hit = 1;
         kept[i] = !hit;
      end
      for (int i = 0; i < tab_count; i++) begin
         if (!kept[i] || emitted >= dbn_pkg::ResultCap) continue;
         r = '{tab_x[i], tab_y[i], tab_w[i], tab_h[i], tab_score[i], 1'b1,
               frame_peak, frame_overflow, 1'b0};
         expected_boxes = {expected_boxes, r};
         emitted++;
      end
      if (emitted == 0) begin
         r = '{13'd0, 13'd0, 13'd0, 13'd0, 16'd0, 1'b0, frame_peak, frame_overflow, 1'b0};
         expected_boxes = {expected_boxes, r};
      end
      expected_boxes[$].last = 1'b1;
      tab_count = 0;
      frame_peak = '0;
      frame_overflow = 1'b0;
   endtask

   // result side
   always @(posedge clock) begin
      dbn_test_pkg::kept_box_type got, want;
      if (!reset && rsp.valid && rsp.ready) begin
         got = '{rsp.out_x, rsp.out_y, rsp.out_w, rsp.out_h, rsp.out_score,
                 rsp.box_valid, rsp.peak_score, rsp.table_overflow, rsp.last_result};
         results_seen++;
         if (expected_boxes.size() == 0) begin
            $display("%0t: unexpected transfer, expected none, actual %p", $time, got);
            errors++;
         end else begin
            want = expected_boxes.pop_front();
            if (got !== want) begin
               $display("%0t: mismatch, expected %p, actual %p", $time, want, got);
               errors++;
            end
         end
      end
   end

   initial rsp.ready = 1'b0;
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (long_hold_req) begin
         rsp.ready <= 1'b0;
         hold_cycles++;
         if (hold_cycles >= 600) begin
            long_hold_req = 0;
            hold_cycles = 0;
         end
      end else if ($urandom_range(0, 3) == 0) begin
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= 1'b1;
      end
   end

   task automatic csr_write(logic [2:0] index, logic [31:0] value);
      @(posedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= dbn_pkg::CsrAddrW'(index) << 2; pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (index)
         dbn_pkg::RegPadLeft:    cfg.pad_left = value[9:0];
         dbn_pkg::RegPadTop:     cfg.pad_top = value[9:0];
         dbn_pkg::RegInvScale:   cfg.inverse_scale = value[15:0];
         dbn_pkg::RegFrameW:     cfg.frame_width = value[12:0];
         dbn_pkg::RegFrameH:     cfg.frame_height = value[12:0];
         dbn_pkg::RegCandThr:    cfg.candidate_threshold = value[15:0];
         dbn_pkg::RegOverlapThr: cfg.overlap_threshold = value[15:0];
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      while (expected_boxes.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic send_prediction(dbn_test_pkg::prediction_type p);
      int gap;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.center_x <= p.cx; req.center_y <= p.cy;
      req.box_span_x <= p.sx; req.box_span_y <= p.sy;
      req.class_score <= p.score; req.last_prediction <= p.last;
      predict_kept_boxes(p);
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      items_sent++;
      if (p.last) frames_sent++;
   endtask

   function automatic dbn_test_pkg::prediction_type random_prediction(bit last);
      dbn_test_pkg::prediction_type p;
      int mode;
      mode = $urandom_range(0, 9);
      if (mode == 0) begin
         p.cx = 16'($urandom);
         p.cy = 16'($urandom);
         p.sx = 16'($urandom);
         p.sy = 16'($urandom);
         p.score = 16'($urandom);
      end else begin
         p.cx = 16'($urandom_range(0, 10000));
         p.cy = 16'($urandom_range(0, 10000));
         p.sx = 16'($urandom_range(0, 4000));
         p.sy = 16'($urandom_range(0, 4000));
         p.score = 16'($urandom);
      end
      p.last = last;
      return p;
   endfunction

   dbn_test_pkg::prediction_type directed_rows [22] = '{
      '{16'sd3200, 16'sd3200, 16'sd1600, 16'sd1600, 16'hFFFF, 1'b0},
      '{16'sd3200, 16'sd3200, 16'sd1600, 16'sd1600, 16'hFFFF, 1'b0},
      '{16'sd3300, 16'sd3200, 16'sd1600, 16'sd1600, 16'hF000, 1'b0},
      '{16'sd8000, 16'sd8000, 16'sd800,  16'sd800,  16'hC000, 1'b1},
      '{16'sd3200, 16'sd3200, 16'sd1600, 16'sd1600, 16'h1000, 1'b1},
      '{16'sh8000, 16'sh8000, 16'sd32767, 16'sd32767, 16'h8000, 1'b1},
      '{16'sd32767, 16'sd32767, 16'sh8000, 16'sh8000, 16'h8000, 1'b1},
      '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'h4000, 1'b1},
      '{16'sd5000, 16'sd5000, 16'sd10, 16'sd10, 16'h9000, 1'b1},
      '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'h0000, 1'b1},
      '{16'sd100, 16'sd6000, 16'sd50, 16'sd300, 16'h7000, 1'b0},
      '{16'sd6000, 16'sd100, 16'sd300, 16'sd50, 16'h7000, 1'b0},
      '{16'sd2000, 16'sd2000, 16'sd3000, 16'sd3000, 16'h6000, 1'b1},
      '{-16'sd1, -16'sd1, 16'sd1, 16'sd1, 16'h5555, 1'b0},
      '{16'sd4000, 16'sd4000, 16'sd2000, 16'sd2000, 16'h4000, 1'b1},
      '{16'sd4000, 16'sd4000, 16'sd2000, 16'sd2000, 16'h3FFF, 1'b1},
      '{16'sd9000, 16'sd9000, 16'sd4000, 16'sd4000, 16'hAAAA, 1'b0},
      '{16'sd9100, 16'sd9000, 16'sd4000, 16'sd4000, 16'hAAAA, 1'b0},
      '{16'sd1000, 16'sd9000, 16'sd1000, 16'sd1000, 16'h5000, 1'b0},
      '{16'sd12000, 16'sd12000, 16'sd500, 16'sd500, 16'hFFFE, 1'b1},
      '{16'sd20000, 16'sd20000, 16'sd200, 16'sd200, 16'h8001, 1'b1},
      '{16'sd20000, 16'sd20000, 16'sd200, 16'sd200, 16'h8001, 1'b1}
   };

   // below threshold, and an all-zero row: each gives one empty record
   dbn_test_pkg::kept_box_type empty_low =
      '{13'd0, 13'd0, 13'd0, 13'd0, 16'd0, 1'b0, 16'h1000, 1'b0, 1'b1};
   dbn_test_pkg::kept_box_type empty_zero =
      '{13'd0, 13'd0, 13'd0, 13'd0, 16'd0, 1'b0, 16'h0000, 1'b0, 1'b1};

   initial begin
      int n;
      dbn_test_pkg::prediction_type p;
      dbn_test_pkg::kept_box_type typed;
      cfg = '{10'd0, 10'd0, dbn_pkg::InvScaleReset, dbn_pkg::FrameReset,
              dbn_pkg::FrameReset, dbn_pkg::CandThrReset, dbn_pkg::OverlapReset};
      tab_count = 0; frame_peak = '0; frame_overflow = 1'b0;
      req.valid = 1'b0;
      req.center_x = '0; req.center_y = '0; req.box_span_x = '0; req.box_span_y = '0;
      req.class_score = '0; req.last_prediction = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < $size(directed_rows); i++) begin
         send_prediction(directed_rows[i]);
         if (i == 4 || i == 9) begin
            typed = (i == 4) ? empty_low : empty_zero;
            if (expected_boxes[$] !== typed) begin
               $display("%0t: row %0d, expected %p, actual %p", $time, i, typed,
                        expected_boxes[$]);
               errors++;
            end
            expected_boxes[$] = typed;
         end
         if (i == 4) begin
            req.valid <= 1'b0;
            wait_drained();
         end
      end
      req.valid <= 1'b0;
      wait_drained();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               csr_write(dbn_pkg::RegPadLeft, 32'd1023);
               csr_write(dbn_pkg::RegPadTop, 32'd1023);
               csr_write(dbn_pkg::RegInvScale, 32'd65535);
               csr_write(dbn_pkg::RegFrameW, 32'd4096);
               csr_write(dbn_pkg::RegFrameH, 32'd4096);
               csr_write(dbn_pkg::RegCandThr, 32'd0);
               csr_write(dbn_pkg::RegOverlapThr, 32'd0);
            end
            1: begin
               csr_write(dbn_pkg::RegPadLeft, 32'd0);
               csr_write(dbn_pkg::RegPadTop, 32'd0);
               csr_write(dbn_pkg::RegInvScale, 32'd1);
               csr_write(dbn_pkg::RegFrameW, 32'd1);
               csr_write(dbn_pkg::RegFrameH, 32'd1);
               csr_write(dbn_pkg::RegOverlapThr, 32'd65535);
            end
            2: begin
               csr_write(dbn_pkg::RegInvScale, 32'd0);
               csr_write(dbn_pkg::RegFrameW, 32'd0);
               csr_write(dbn_pkg::RegCandThr, 32'd65535);
            end
            default: begin
               csr_write(dbn_pkg::RegPadLeft, $urandom_range(0, 100));
               csr_write(dbn_pkg::RegPadTop, $urandom_range(0, 100));
               csr_write(dbn_pkg::RegInvScale, $urandom_range(2048, 12000));
               csr_write(dbn_pkg::RegFrameW, $urandom_range(200, 4096));
               csr_write(dbn_pkg::RegFrameH, $urandom_range(200, 4096));
               csr_write(dbn_pkg::RegCandThr, $urandom_range(0, 40000));
               csr_write(dbn_pkg::RegOverlapThr, $urandom_range(0, 65535));
            end
         endcase
         n = (phase < 3) ? 20 : 110;
         for (int k = 0; k < n; k++) begin
            if (phase == 4 && k == 0) long_hold_req = 1;
            p = random_prediction(($urandom_range(0, 9) == 0) || k == n - 1);
            if (phase == 5 && k < 40) p.last = (k == 39);
            send_prediction(p);
         end
         req.valid <= 1'b0;
         wait_drained();
      end

      $display("Sent %0d predictions in %0d frames; %0d results checked.",
               items_sent, frames_sent, results_seen);
      $display("Covered extreme registers, empty frames, table overflow and long stalls.");
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #100ms;
      $display("Timeout");
      $display("*** FAILED ***");
      $finish;
   end
endmodule

// ----- files.f -----
rtl/dbn_pkg.sv
rtl/dbn_if.sv
rtl/dbn_csr.sv
rtl/dbn_ctrl.sv
rtl/dbn_dpath.sv
rtl/detection_box_decode_and_nms.sv
test/dbn_test_if.sv
test/detection_box_decode_and_nms_test.sv
